### hw/rtl/rm_pkg.sv
// Shared types for the running median block: chain commands and cell links.
// No dependencies; every other file of the block imports this package.
package rm_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 11;

  typedef logic signed [DATA_W-1:0] rm_data_t;

  // What a chain does with the broadcast value.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP_INSERT
  } rm_op_t;

  typedef struct packed {
    rm_op_t   op;
    rm_data_t value;
  } rm_cmd_t;

  // What a cell shows its neighbors: its value and whether the broadcast
  // value sorts before it.
  typedef struct packed {
    rm_data_t value;
    logic     lt;
  } rm_link_t;

endpackage

### hw/rtl/rm_cell.sv
// One slot of a sorted chain: holds one value and picks its next value from
// itself, its neighbors or the broadcast value. Depends on rm_pkg.
module rm_cell #(
  parameter bit FIRST   = 1'b0,
  parameter bit DESCEND = 1'b0
) (
  input  logic             clk,
  input  rm_pkg::rm_cmd_t  cmd,
  input  logic             occ,
  input  rm_pkg::rm_link_t prev,
  input  rm_pkg::rm_link_t next,
  output rm_pkg::rm_link_t self,
  output rm_pkg::rm_data_t value_nxt
);
  import rm_pkg::*;

  rm_data_t value_r;
  logic     ahead;

  // An empty slot sorts after everything.
  always_comb begin
    if (DESCEND) begin
      ahead = cmd.value > value_r;
    end else begin
      ahead = cmd.value < value_r;
    end
  end

  assign self.value = value_r;
  assign self.lt    = !occ || ahead;

  always_comb begin
    unique case (cmd.op)
      OP_HOLD: begin
        value_nxt = value_r;
      end
      OP_INSERT: begin
        if (!self.lt) begin
          value_nxt = value_r;
        end else if (FIRST || !prev.lt) begin
          value_nxt = cmd.value;
        end else begin
          value_nxt = prev.value;
        end
      end
      OP_POP_INSERT: begin
        // Head leaves; every value ahead of the new value moves up one slot.
        if (!next.lt) begin
          value_nxt = next.value;
        end else if (FIRST || !self.lt) begin
          value_nxt = cmd.value;
        end else begin
          value_nxt = value_r;
        end
      end
      default: begin
        value_nxt = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

### hw/rtl/rm_chain.sv
// Row of rm_cell slots kept sorted with the head in slot 0; one insert or
// pop-and-insert per cycle. Depends on rm_pkg and rm_cell.
module rm_chain #(
  parameter int unsigned DEPTH   = 512,
  parameter bit          DESCEND = 1'b0
) (
  input  logic                         clk,
  input  rm_pkg::rm_cmd_t              cmd,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  output rm_pkg::rm_data_t             head,
  output rm_pkg::rm_data_t             head_nxt
);
  import rm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rm_link_t links [DEPTH];
  rm_data_t nxt   [DEPTH];
  rm_link_t edge_left;
  rm_link_t edge_right;

  assign edge_left.value  = '0;
  assign edge_left.lt     = 1'b0;
  assign edge_right.value = '0;
  assign edge_right.lt    = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rm_link_t prev_l;
    rm_link_t next_l;
    logic     occ;

    assign occ = count > CNT_W'(i);

    if (i == 0) begin : g_left
      assign prev_l = edge_left;
    end else begin : g_mid_l
      assign prev_l = links[i-1];
    end

    if (i == DEPTH - 1) begin : g_right
      assign next_l = edge_right;
    end else begin : g_mid_r
      assign next_l = links[i+1];
    end

    rm_cell #(
      .FIRST   (i == 0),
      .DESCEND (DESCEND)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ),
      .prev      (prev_l),
      .next      (next_l),
      .self      (links[i]),
      .value_nxt (nxt[i])
    );
  end

  assign head     = links[0].value;
  assign head_nxt = nxt[0];

endmodule

### hw/rtl/running_median.sv
// Running lower median over a stream of signed samples, top level.
// Depends on rm_pkg and rm_chain (two sorted chains of rm_cell slots).
//
//   channel  handshake             fields                                  beat
//   in       in_valid/in_ready     in_sample in_restart                    one sample
//   out      out_valid/out_ready   out_median out_held_count out_refused   one result
//
// One sample is taken per cycle while in_ready is high; its result is
// registered and shows on the next cycle. The lower half of the values
// sits in a descending chain whose head is the median, the upper half in
// an ascending chain; each beat moves at most one value across.
// Reset empties both chains at once. A stalled result holds the input side
// only while out_valid is high and out_ready is low.
module running_median #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rm_pkg::rm_data_t        in_sample,
  input  logic                    in_restart,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rm_pkg::rm_data_t        out_median,
  output logic [rm_pkg::COUNT_W-1:0] out_held_count,
  output logic                    out_refused
);
  import rm_pkg::*;

  localparam int unsigned LO_CAP = (CAPACITY + 1) / 2;
  localparam int unsigned HI_CAP = CAPACITY / 2;
  localparam int unsigned LO_W   = $clog2(LO_CAP + 1);
  localparam int unsigned HI_W   = $clog2(HI_CAP + 1);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

  logic [LO_W-1:0]  lo_cnt_r, lo_cnt_nxt, lo_cnt_eff;
  logic [HI_W-1:0]  hi_cnt_r, hi_cnt_nxt, hi_cnt_eff;
  logic [CNT_W-1:0] total_eff, total_nxt;
  logic [CNT_W+COUNT_W-1:0] total_ext;
  logic             accept, full, even;
  rm_cmd_t          lo_cmd, hi_cmd;
  rm_data_t         lo_head, lo_head_nxt, hi_head;

  logic             out_valid_r, out_valid_nxt;
  rm_data_t         median_r;
  logic [COUNT_W-1:0] held_r;
  logic             refused_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Restart empties the store before this beat's sample goes in.
  assign lo_cnt_eff = in_restart ? '0 : lo_cnt_r;
  assign hi_cnt_eff = in_restart ? '0 : hi_cnt_r;
  assign total_eff  = CNT_W'(lo_cnt_eff) + CNT_W'(hi_cnt_eff);
  assign full       = total_eff >= CNT_W'(CAPACITY);
  assign even       = CNT_W'(lo_cnt_eff) == CNT_W'(hi_cnt_eff);

  always_comb begin
    lo_cmd.op    = OP_HOLD;
    lo_cmd.value = in_sample;
    hi_cmd.op    = OP_HOLD;
    hi_cmd.value = in_sample;
    lo_cnt_nxt   = lo_cnt_r;
    hi_cnt_nxt   = hi_cnt_r;
    if (accept && !full) begin
      if (even) begin
        lo_cnt_nxt = lo_cnt_eff + 1'b1;
        hi_cnt_nxt = hi_cnt_eff;
        if (hi_cnt_eff == '0 || in_sample <= hi_head) begin
          lo_cmd.op = OP_INSERT;
        end else begin
          // Upper head drops into the lower half; sample takes its place.
          lo_cmd.op    = OP_INSERT;
          lo_cmd.value = hi_head;
          hi_cmd.op    = OP_POP_INSERT;
        end
      end else begin
        lo_cnt_nxt = lo_cnt_eff;
        hi_cnt_nxt = hi_cnt_eff + 1'b1;
        if (in_sample >= lo_head) begin
          hi_cmd.op = OP_INSERT;
        end else begin
          // Lower head rises into the upper half; sample takes its place.
          lo_cmd.op    = OP_POP_INSERT;
          hi_cmd.op    = OP_INSERT;
          hi_cmd.value = lo_head;
        end
      end
    end
  end

  rm_chain #(
    .DEPTH   (LO_CAP),
    .DESCEND (1'b1)
  ) u_lo (
    .clk      (clk),
    .cmd      (lo_cmd),
    .count    (lo_cnt_eff),
    .head     (lo_head),
    .head_nxt (lo_head_nxt)
  );

  rm_chain #(
    .DEPTH   (HI_CAP),
    .DESCEND (1'b0)
  ) u_hi (
    .clk      (clk),
    .cmd      (hi_cmd),
    .count    (hi_cnt_eff),
    .head     (hi_head),
    .head_nxt ()
  );

  assign total_nxt = CNT_W'(lo_cnt_nxt) + CNT_W'(hi_cnt_nxt);
  assign total_ext = {{COUNT_W{1'b0}}, total_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_cnt_r    <= '0;
      hi_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lo_cnt_r    <= lo_cnt_nxt;
      hi_cnt_r    <= hi_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      median_r  <= lo_head_nxt;
      held_r    <= total_ext[COUNT_W-1:0];
      refused_r <= full;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_median     = median_r;
  assign out_held_count = held_r;
  assign out_refused    = refused_r;

endmodule
